// ----- sv/sps_pkg.sv -----
// Package: payload structs, mode codes, constants and the port A reorder function for the switch play selector.
`default_nettype none
package sps_pkg;
	localparam int MaxSwitches = 12;

	typedef enum logic [3:0] {
		MODE_NONE     = 4'd0,
		MODE_RR       = 4'd1,
		MODE_LAST     = 4'd2,
		MODE_PRIO     = 4'd3,
		MODE_HELD     = 4'd4,
		MODE_B127N    = 4'd5,
		MODE_B250P    = 4'd6,
		MODE_B250N    = 4'd7,
		MODE_B255P    = 4'd8,
		MODE_B255N    = 4'd9,
		MODE_B255NI   = 4'd10,
		MODE_LASTV    = 4'd11
	} mode_t;

	localparam logic [0:0] REG_PLAY_MODE    = 1'b0;
	localparam logic [0:0] REG_SWITCH_COUNT = 1'b1;

	typedef struct packed {
		logic       irq;
		logic [7:0] port_a;
		logic [7:0] port_b;
		logic       playing;
		logic       waiting;
	} in_t;

	typedef struct packed {
		logic       enqueue;
		logic [7:0] track;
		logic       playing_next;
		logic       waiting_next;
		logic       clear_errors;
		logic       flush_queue;
	} out_t;

	function automatic logic [7:0] reorder_a(input logic [7:0] raw);
		logic [7:0] o;
		o = ~raw;
		return {o[0], o[1], o[2], o[3], o[7:4]};
	endfunction
endpackage
`default_nettype wire

// ----- sv/switch_play_selector.sv -----
// Top level: debounced switch sampling and track selection.
// One input transaction is taken into a register (s1), all selection logic is evaluated in
// a single combinational pass from that register and the selector state, and the result
// is registered into an output register (s2). A transaction is accepted every cycle while
// the output is free or being taken (in_stall is only high while a result waits under
// out_stall), so the sustained rate is one item per cycle.
// State updates are committed when an item leaves s1. Configuration writes (index 0
// play_mode, 1 switch_count) take effect at the next edge; write only while idle.
`default_nettype none
module switch_play_selector (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sps_pkg::in_t       in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sps_pkg::out_t           out_data,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [3:0]         cfg_data
);
	logic [3:0] mode_q, count_q;
	logic [7:0] pa_last_q, pb_last_q, last_sw_q;
	logic [11:0] comb_last_q, armed_q, armed_v_q;
	logic [3:0] cnt_last_q;
	logic stop_seen_q;

	logic v_s1;
	sps_pkg::in_t d_s1;
	logic v_s2;
	sps_pkg::out_t d_s2;

	logic adv;  // s1 moves into s2
	assign adv = v_s1 && !(v_s2 && out_stall);
	assign in_stall = v_s1 && !adv;
	assign out_valid = v_s2;
	assign out_data = d_s2;

	// next-state and result logic
	logic [7:0] n_pa, n_pb, n_ls;
	logic [11:0] n_comb, n_armed, n_armed_v;
	logic [3:0] n_cnt;
	logic n_ss;
	sps_pkg::out_t res;

	always_comb begin
		logic [3:0] n;
		logic [11:0] en, comb, cs, cand, mask;
		logic [7:0] a, b, da, db, c;
		logic stop, found, pl, wt, enq, clr, fl, held, stb, put, halt;
		logic [3:0] idx, low, cntv;
		logic signed [8:0] ls;
		n = (count_q > 4'(sps_pkg::MaxSwitches)) ? 4'(sps_pkg::MaxSwitches) : count_q;
		for (int i = 0; i < 12; i++) en[i] = (4'(i) < n);
		n_pa = pa_last_q; n_pb = pb_last_q; n_ls = last_sw_q; n_comb = comb_last_q;
		n_armed = armed_q; n_armed_v = armed_v_q; n_cnt = cnt_last_q; n_ss = stop_seen_q;
		pl = d_s1.playing; wt = d_s1.waiting; enq = 1'b0; clr = 1'b0; fl = 1'b0;
		c = '0; idx = '0; low = '0; found = 1'b0; held = 1'b0; stb = 1'b0;
		put = 1'b0; halt = 1'b0; cand = '0; mask = '0; cntv = '0;
		a = sps_pkg::reorder_a(d_s1.port_a);
		b = ~d_s1.port_b;
		da = '0; db = '0; comb = '0; cs = '0; stop = 1'b0;
		ls = {last_sw_q[7], last_sw_q};
		unique case (mode_q)
			sps_pkg::MODE_RR, sps_pkg::MODE_LAST, sps_pkg::MODE_PRIO,
			sps_pkg::MODE_HELD, sps_pkg::MODE_LASTV: begin
				if (d_s1.irq) begin
					da = pa_last_q & a; db = pb_last_q & b;
					n_pa = a; n_pb = b;
					comb = {db[6:3], da};
					stop = db[0];
				end else begin
					n_pa = '0; n_pb = '0;
				end
				// comb is kept whole for history and hold tests; picks see scanned bits only
				cs = comb & en;
				// round-robin pick: first above signed last, else lowest
				found = 1'b0; low = '0;
				for (int i = 11; i >= 0; i--) if (cs[i]) low = 4'(i);
				for (int i = 11; i >= 0; i--)
					if (cs[i] && ($signed({5'd0, 4'(i)}) > ls)) begin
						found = 1'b1; idx = 4'(i);
					end
				if (!found) idx = low;
				case (mode_q)
					sps_pkg::MODE_RR: begin
						if (d_s1.irq) begin
							if (stop) begin
								pl = 1'b0; wt = 1'b0;
								if (!stop_seen_q) n_ls = last_sw_q - 8'd1;
								n_ss = 1'b1; clr = 1'b1;
							end else if (!pl && !wt) begin
								n_ss = 1'b0;
								if (cs != '0) begin
									enq = 1'b1; c = {4'd0, idx}; n_ls = {4'd0, idx};
								end
							end
						end
					end
					sps_pkg::MODE_PRIO: begin
						if (d_s1.irq) begin
							if (stop) begin
								pl = 1'b0; clr = 1'b1;
							end else begin
								ls = pl ? {1'b0, last_sw_q} : 9'd255;
								if (!pl) n_ls = 8'd255;
								cand = '0;
								for (int i = 0; i < 12; i++)
									cand[i] = cs[i] && ({5'd0, 4'(i)} < ls);
								if (cand != '0) begin
									idx = '0;
									for (int i = 11; i >= 0; i--) if (cand[i]) idx = 4'(i);
									pl = 1'b0; enq = 1'b1; c = {4'd0, idx}; n_ls = {4'd0, idx};
								end
							end
						end
					end
					sps_pkg::MODE_HELD: begin
						if (!d_s1.irq) begin
							pl = 1'b0; n_ss = 1'b0;
						end else begin
							held = (last_sw_q < 8'd12) ? comb[last_sw_q[3:0]] : 1'b0;
							if (!held) pl = 1'b0;
							n_comb = comb;
							if (stop) begin
								pl = 1'b0; clr = 1'b1; n_ss = 1'b1;
							end else if (!pl && !stop_seen_q && cs != '0) begin
								enq = 1'b1; c = {4'd0, idx}; n_ls = {4'd0, idx};
							end
						end
					end
					default: begin
						mask = (mode_q == sps_pkg::MODE_LAST) ? armed_q : armed_v_q;
						cntv = '0;
						if (!d_s1.irq) begin
							mask = 12'hFFF;
						end else begin
							for (int i = 0; i < 12; i++) cntv = cntv + 4'(cs[i]);
							if (stop) begin
								pl = 1'b0; clr = 1'b1;
							end else if (comb_last_q != comb) begin
								if (cntv > cnt_last_q) begin
									for (int i = 0; i < 12; i++)
										cand[i] = cs[i] && mask[i] &&
											(mode_q == sps_pkg::MODE_LAST || !pl ||
											 last_sw_q != 8'(i));
									if (cand != '0) begin
										idx = '0;
										for (int i = 11; i >= 0; i--) if (cand[i]) idx = 4'(i);
										pl = 1'b0; enq = 1'b1; c = {4'd0, idx};
										if (mode_q == sps_pkg::MODE_LASTV) n_ls = {4'd0, idx};
										mask[idx] = 1'b0;
									end
								end else begin
									mask = ~comb;
								end
							end
						end
						if (mode_q == sps_pkg::MODE_LAST) n_armed = mask;
						else n_armed_v = mask;
						n_comb = comb; n_cnt = cntv;
					end
				endcase
			end
			sps_pkg::MODE_B127N, sps_pkg::MODE_B250P, sps_pkg::MODE_B250N,
			sps_pkg::MODE_B255P, sps_pkg::MODE_B255N, sps_pkg::MODE_B255NI: begin
				if (!d_s1.irq) begin
					n_ls = '0; n_pb = '0;
				end else begin
					a = ~a;
					da = pa_last_q & a; db = pb_last_q & b;
					n_pa = a; n_pb = b;
					stb = db[1];
					if (db[0]) begin
						pl = 1'b0; clr = 1'b1; fl = 1'b1;
					end else if (mode_q != sps_pkg::MODE_B255NI || !pl) begin
						if (stb && last_sw_q != 8'd2) begin
							c = da;
							case (mode_q)
								sps_pkg::MODE_B127N: begin
									if (da[6:0] == 7'h7F) halt = 1'b1;
									else begin c = 8'h7E - {1'b0, da[6:0]}; put = 1'b1; end
								end
								sps_pkg::MODE_B250P, sps_pkg::MODE_B250N: begin
									if (da == 8'hFF) halt = 1'b1;
									else if (da != 8'h00 && da < 8'hFB) begin
										c = (mode_q == sps_pkg::MODE_B250P) ? da - 8'h01 :
											8'hFA - da;
										put = 1'b1;
									end
								end
								sps_pkg::MODE_B255P: begin
									if (da == 8'h00) halt = 1'b1;
									else begin c = da - 8'h01; put = 1'b1; end
								end
								default: begin
									if (da == 8'hFF) halt = (mode_q == sps_pkg::MODE_B255N);
									else begin c = 8'hFE - da; put = 1'b1; end
								end
							endcase
							if (halt) begin pl = 1'b0; fl = 1'b1; end
							enq = put;
							n_ls = 8'd2;
						end else if (!stb) begin
							n_ls = '0;
						end
					end
				end
			end
			default: ;
		endcase
		res.enqueue = enq;
		res.track = enq ? c : 8'd0;
		res.playing_next = pl;
		res.waiting_next = wt;
		res.clear_errors = clr;
		res.flush_queue = fl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
			mode_q <= sps_pkg::MODE_NONE; count_q <= 4'd12;
			pa_last_q <= '0; pb_last_q <= '0; last_sw_q <= 8'd255;
			comb_last_q <= 12'd255; cnt_last_q <= '0; stop_seen_q <= 1'b0;
			armed_q <= 12'hFFF; armed_v_q <= 12'hFFF;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sps_pkg::REG_PLAY_MODE) mode_q <= cfg_data;
				else count_q <= cfg_data;
			end
			if (!in_stall) v_s1 <= in_valid;
			if (adv) begin
				v_s2 <= 1'b1;
				pa_last_q <= n_pa; pb_last_q <= n_pb; last_sw_q <= n_ls;
				comb_last_q <= n_comb; cnt_last_q <= n_cnt; stop_seen_q <= n_ss;
				armed_q <= n_armed; armed_v_q <= n_armed_v;
			end else if (!out_stall) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) d_s1 <= in_data;
		if (adv) d_s2 <= res;
	end
endmodule
`default_nettype wire

// ----- sv/sps_checker.sv -----
// Port-level checker for the switch play selector, bound to the top level.
`default_nettype none
module sps_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire sps_pkg::out_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");
	a_trk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.enqueue |-> out_data.track == 8'd0)
		else $error("track set without enqueue");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall |=> out_valid)
		else $error("result missing");
endmodule
bind switch_play_selector sps_checker u_sps_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire

// ----- test/switch_play_selector_tb.sv -----
// Testbench: directed and random checks of the switch play selector against a local predictor.
`default_nettype none
module switch_play_selector_tb;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	sps_pkg::in_t in_data;
	logic out_valid;
	logic out_stall;
	sps_pkg::out_t out_data;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [3:0] cfg_data;

	switch_play_selector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the configuration and selector state
	logic [3:0] pm_mode;
	logic [3:0] pm_count;
	logic [7:0] pa_hist;
	logic [7:0] pb_hist;
	logic [7:0] sel_last;
	logic [11:0] comb_hist;
	logic [3:0] cnt_hist;
	logic stop_flag;
	logic [11:0] arm_main;
	logic [11:0] arm_var;

	sps_pkg::out_t track_queue[$];
	int errors = 0;
	bit idle_off = 0;       // long stretch without random idling
	bit hold_recv = 0;      // receiver hold-off request
	int hold_len = 0;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic logic [7:0] swizzle_a(input logic [7:0] raw);
		logic [7:0] o;
		o = ~raw;
		return {o[0], o[1], o[2], o[3], o[7:4]};
	endfunction

	function automatic int scan_width();
		return (pm_count > sps_pkg::MaxSwitches) ? sps_pkg::MaxSwitches : int'(pm_count);
	endfunction

	// next pressed above the last switch (signed compare), else the lowest pressed
	function automatic bit rr_pick(input logic [11:0] comb, output logic [7:0] trk);
		int ls;
		int low;
		ls = $signed(sel_last);
		low = -1;
		trk = 8'd0;
		for (int i = 0; i < scan_width(); i++) begin
			if (comb[i]) begin
				if (low < 0) low = i;
				if (i > ls) begin
					sel_last = i[7:0];
					trk = i[7:0];
					return 1'b1;
				end
			end
		end
		if (low >= 0) begin
			sel_last = low[7:0];
			trk = low[7:0];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic sps_pkg::out_t predict_selection(input sps_pkg::in_t it);
		sps_pkg::out_t r;
		logic playing, waiting, enq, clr, flush, irq, stop, held, stb;
		logic [7:0] trk, a, b, da, db;
		logic [11:0] comb;
		int cnt, n;
		logic [8:0] code;
		bit put, halt, done;
		irq = it.irq;
		playing = it.playing;
		waiting = it.waiting;
		enq = 0; clr = 0; flush = 0; trk = 0;
		n = scan_width();
		comb = 0; cnt = 0; stop = 0;
		if ((pm_mode >= sps_pkg::MODE_RR && pm_mode <= sps_pkg::MODE_HELD) ||
		    pm_mode == sps_pkg::MODE_LASTV) begin
			if (irq) begin
				a = swizzle_a(it.port_a);
				b = ~it.port_b;
				da = pa_hist & a;
				db = pb_hist & b;
				pa_hist = a;
				pb_hist = b;
				comb = {db[6:3], da};
				stop = db[0];
			end
			if (pm_mode == sps_pkg::MODE_RR) begin
				if (!irq) begin
					pa_hist = 0; pb_hist = 0;
				end else if (stop) begin
					playing = 0; waiting = 0;
					if (!stop_flag) sel_last = sel_last - 8'd1;
					stop_flag = 1; clr = 1;
				end else if (!playing && !waiting) begin
					stop_flag = 0;
					enq = rr_pick(comb, trk);
				end
			end else if (pm_mode == sps_pkg::MODE_PRIO) begin
				if (!irq) begin
					pa_hist = 0; pb_hist = 0;
				end else if (stop) begin
					playing = 0; clr = 1;
				end else begin
					if (!playing) sel_last = 8'hFF;
					done = 0;
					for (int i = 0; i < n; i++) begin
						if (!done && comb[i] && i < sel_last) begin
							playing = 0; enq = 1; trk = i[7:0]; sel_last = i[7:0];
							done = 1;
						end
					end
				end
			end else if (pm_mode == sps_pkg::MODE_HELD) begin
				if (!irq) begin
					pa_hist = 0; pb_hist = 0; playing = 0; stop_flag = 0;
				end else begin
					held = (sel_last < 16) ? comb[sel_last[3:0]] : 1'b0;
					if (sel_last >= 12 && sel_last < 16) held = 1'b0;
					if (!held) playing = 0;
					comb_hist = comb;
					if (stop) begin
						playing = 0; clr = 1; stop_flag = 1;
					end else if (!playing && !stop_flag) begin
						enq = rr_pick(comb, trk);
					end
				end
			end else begin
				if (!irq) begin
					pa_hist = 0; pb_hist = 0;
					if (pm_mode == sps_pkg::MODE_LAST) arm_main = 12'hFFF;
					else arm_var = 12'hFFF;
				end else begin
					for (int i = 0; i < n; i++) cnt += comb[i];
					if (stop) begin
						playing = 0; clr = 1;
					end else if (comb_hist != comb) begin
						if (cnt > cnt_hist) begin
							done = 0;
							for (int i = 0; i < n; i++) begin
								if (!done && comb[i] && ((pm_mode == sps_pkg::MODE_LAST) ?
								    arm_main[i] : arm_var[i])) begin
									if (pm_mode == sps_pkg::MODE_LAST || !playing ||
									    sel_last != i) begin
										playing = 0; enq = 1; trk = i[7:0];
										if (pm_mode == sps_pkg::MODE_LASTV) sel_last = i[7:0];
										if (pm_mode == sps_pkg::MODE_LAST) arm_main[i] = 1'b0;
										else arm_var[i] = 1'b0;
										done = 1;
									end
								end
							end
						end else if (pm_mode == sps_pkg::MODE_LAST) begin
							arm_main = ~comb;
						end else begin
							arm_var = ~comb;
						end
					end
				end
				comb_hist = comb;
				cnt_hist = cnt[3:0];
			end
		end else if (pm_mode >= sps_pkg::MODE_B127N && pm_mode <= sps_pkg::MODE_B255NI) begin
			if (!irq) begin
				sel_last = 0; pb_hist = 0;
			end else begin
				a = swizzle_a(it.port_a) ^ 8'hFF;
				b = ~it.port_b;
				da = pa_hist & a;
				db = pb_hist & b;
				pa_hist = a;
				pb_hist = b;
				if (db[0]) begin
					playing = 0; clr = 1; flush = 1;
				end else if (pm_mode != sps_pkg::MODE_B255NI || !playing) begin
					stb = db[1];
					if (stb && sel_last != 8'd2) begin
						code = {1'b0, da};
						put = 0; halt = 0;
						case (pm_mode)
						sps_pkg::MODE_B127N: begin
							code = code & 9'h7F;
							if (code == 9'h7F) halt = 1;
							else begin code = 9'h7E - code; put = 1; end
						end
						sps_pkg::MODE_B250P, sps_pkg::MODE_B250N: begin
							if (code == 9'hFF) halt = 1;
							else if (code != 9'd0 && code < 9'hFB) begin
								code = (pm_mode == sps_pkg::MODE_B250P) ? code - 9'd1 :
									9'hFA - code;
								put = 1;
							end
						end
						sps_pkg::MODE_B255P: begin
							if (code == 9'd0) halt = 1;
							else begin code = code - 9'd1; put = 1; end
						end
						default: begin
							if (code == 9'hFF) halt = (pm_mode == sps_pkg::MODE_B255N);
							else begin code = 9'hFE - code; put = 1; end
						end
						endcase
						if (halt) begin playing = 0; flush = 1; end
						if (put) begin enq = 1; trk = code[7:0]; end
						sel_last = 8'd2;
					end else if (!stb) begin
						sel_last = 0;
					end
				end
			end
		end
		r.enqueue = enq;
		r.track = enq ? trk : 8'd0;
		r.playing_next = playing;
		r.waiting_next = waiting;
		r.clear_errors = clr;
		r.flush_queue = flush;
		return r;
	endfunction

	// one transaction in; prediction made at acceptance; valid stays up for the next caller
	task automatic send_item(input sps_pkg::in_t it);
		while (!idle_off && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_queue.push_back(predict_selection(it));
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (track_queue.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == sps_pkg::REG_PLAY_MODE) pm_mode = val;
		else pm_count = val;
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		sps_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (track_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				want = track_queue.pop_front();
				if (want.enqueue !== out_data.enqueue)
					$display("%0t: enqueue exp %h got %h", $time, want.enqueue, out_data.enqueue);
				if (want.track !== out_data.track)
					$display("%0t: track exp %h got %h", $time, want.track, out_data.track);
				if (want.playing_next !== out_data.playing_next)
					$display("%0t: playing exp %h got %h", $time,
						want.playing_next, out_data.playing_next);
				if (want.waiting_next !== out_data.waiting_next)
					$display("%0t: waiting exp %h got %h", $time,
						want.waiting_next, out_data.waiting_next);
				if (want.clear_errors !== out_data.clear_errors)
					$display("%0t: clear_errors exp %h got %h", $time,
						want.clear_errors, out_data.clear_errors);
				if (want.flush_queue !== out_data.flush_queue)
					$display("%0t: flush exp %h got %h", $time,
						want.flush_queue, out_data.flush_queue);
				if (want !== out_data) errors++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_recv && hold_len < 40) begin
			out_stall <= 1'b1;
			hold_len <= hold_len + 1;
		end else begin
			out_stall <= !idle_off && ($urandom_range(99) < 12);
		end
	end

	function automatic sps_pkg::in_t rand_item();
		sps_pkg::in_t it;
		it.irq = ($urandom_range(9) != 0);
		it.port_a = 8'($urandom);
		it.port_b = 8'($urandom);
		it.playing = 1'($urandom);
		it.waiting = 1'($urandom);
		return it;
	endfunction

	// press pattern repeated so the debounce lets it through
	task automatic send_held(input sps_pkg::in_t it, input int reps);
		for (int k = 0; k < reps; k++) send_item(it);
	endtask

	task automatic test_directed();
		sps_pkg::in_t it;
		logic [3:0] modes[$] = '{sps_pkg::MODE_NONE, sps_pkg::MODE_RR, sps_pkg::MODE_LAST,
			sps_pkg::MODE_PRIO, sps_pkg::MODE_HELD, sps_pkg::MODE_B127N, sps_pkg::MODE_B250P,
			sps_pkg::MODE_B250N, sps_pkg::MODE_B255P, sps_pkg::MODE_B255N,
			sps_pkg::MODE_B255NI, sps_pkg::MODE_LASTV, 4'd13};
		foreach (modes[m]) begin
			write_reg(sps_pkg::REG_PLAY_MODE, modes[m]);
			it = '{irq: 1'b1, port_a: 8'h00, port_b: 8'hFF, playing: 1'b0, waiting: 1'b0};
			send_held(it, 2);
			it.port_a = 8'hFF; it.port_b = 8'hFC;
			send_held(it, 2);
		end
		it = '{irq: 1'b0, port_a: 8'hAA, port_b: 8'h55, playing: 1'b1, waiting: 1'b1};
		send_item(it);
	endtask

	task automatic test_modes_random(input int items);
		sps_pkg::in_t it, prev;
		prev = rand_item();
		for (int k = 0; k < items; k++) begin
			if ($urandom_range(99) < 30) begin
				send_item(prev);  // repeat gives debounced presses
			end else begin
				it = rand_item();
				// mostly pressed switches sparse and stop released
				if ($urandom_range(3) != 0) it.port_b[0] = 1'b1;
				if ($urandom_range(1) != 0) it.port_a = it.port_a | (8'($urandom) & 8'hF0);
				prev = it;
				send_item(it);
			end
		end
	endtask

	task automatic test_config_sweep();
		logic [3:0] counts[$] = '{4'd12, 4'd1, 4'd0, 4'd15, 4'd5};
		for (int m = 0; m < 16; m++) begin
			write_reg(sps_pkg::REG_PLAY_MODE, m[3:0]);
			write_reg(sps_pkg::REG_SWITCH_COUNT, counts[m % counts.size()]);
			test_modes_random(80);
		end
	endtask

	task automatic test_no_idle();
		idle_off = 1;
		write_reg(sps_pkg::REG_PLAY_MODE, sps_pkg::MODE_LAST);
		write_reg(sps_pkg::REG_SWITCH_COUNT, 4'd12);
		test_modes_random(150);
		idle_off = 0;
	endtask

	task automatic test_backpressure();
		write_reg(sps_pkg::REG_PLAY_MODE, sps_pkg::MODE_RR);
		hold_len = 0;
		hold_recv = 1;
		test_modes_random(60);
		hold_recv = 0;
		drain();  // sender waits for every result
		test_modes_random(20);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pm_mode = sps_pkg::MODE_NONE; pm_count = 4'd12;
		pa_hist = 0; pb_hist = 0; sel_last = 8'hFF; comb_hist = 12'h0FF;
		cnt_hist = 0; stop_flag = 0; arm_main = 12'hFFF; arm_var = 12'hFFF;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_config_sweep();
		test_no_idle();
		test_backpressure();
		drain();
		if (errors == 0) $display("switch_play_selector_tb: done, clean");
		else $display("switch_play_selector_tb: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("switch_play_selector_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
